// ----- rtl/clrr_pkg.sv -----
// ----------------------------------------------------------------------------
// clrr_pkg
// Shared types and constants of the circular list block: item layouts,
// status codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package clrr_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int POS_W          = 12;
    localparam int VAL_W          = 32;
    localparam int TAG_W          = 16;
    localparam int LEN_W          = 7;
    localparam int BIT_CNT_W      = $clog2(POS_W + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                      operation;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
        logic [TAG_W-1:0]         tag;
        logic [POS_W-1:0]         skip_count;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  removed_value;
        logic [TAG_W-1:0]         removed_tag;
        status_t                  status;
        logic [LEN_W-1:0]         list_length;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    setup;
        logic    take;
        logic    link_self;
        logic    mod_step;
        logic    walk;
        logic    ins_link1;
        logic    ins_link2;
        logic    rem_commit;
        logic    rem_finish;
        logic    fin_err;
        status_t err_code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic empty;
        logic full;
        logic mod_last;
        logic steps_zero;
    } sts_t;

endpackage

// ----- rtl/circular_list_rotating_remove.sv -----
// ----------------------------------------------------------------------------
// circular_list_rotating_remove
// Circular singly linked list of (value, tag) entries in a fixed node pool,
// with positional insert and rotating remove.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result for one cycle with done high, and the receiver cannot stall it. The
// block handles one item at a time. A rejected item (insert into a full pool,
// remove from an empty list) is answered at the error check, with no walk. An
// insert into an empty list links the new node to itself and needs no walk.
// Any other insert or remove walks s links, where s is the walk length reduced
// modulo the list length (0 to list_length-1). That reduction is done first in a
// bit-serial remainder unit; the walk then follows one link per cycle through
// the read port of the link memory. No memory clearing is needed after reset.
module circular_list_rotating_remove #(
    parameter int POOL_DEPTH = clrr_pkg::POOL_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  clrr_pkg::req_t request,
    output logic           done,
    output clrr_pkg::rsp_t result
);

    import clrr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    clrr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    clrr_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (request),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (result)
    );

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a busy cycle");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_err_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |->
            ((result.removed_value == '0) && (result.removed_tag == '0)))
        else $error("rejected item carries a removed entry");

    a_single_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.fin_err, cmd.link_self, cmd.ins_link2, cmd.rem_finish}) <= 1)
        else $error("two finishing commands in one cycle");

endmodule

// ----- rtl/clrr_ram.sv -----
// ----------------------------------------------------------------------------
// clrr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module clrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/clrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// clrr_ctrl
// Operation sequencer: error checks, node allocation, walk length remainder,
// link walk and pointer update.
// ----------------------------------------------------------------------------
module clrr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output clrr_pkg::cmd_t cmd,
    input  clrr_pkg::sts_t sts
);

    import clrr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECIDE   = 9'b000000010,
        S_ALLOC    = 9'b000000100,
        S_TAKE     = 9'b000001000,
        S_MOD      = 9'b000010000,
        S_PRIME    = 9'b000100000,
        S_WALK     = 9'b001000000,
        S_INS_LINK = 9'b010000000,
        S_REM_DATA = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.setup = 1'b1;
                if (sts.is_insert)
                begin
                    if (sts.full)
                    begin
                        cmd.fin_err  = 1'b1;
                        cmd.err_code = ST_FULL;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.fin_err  = 1'b1;
                    cmd.err_code = ST_EMPTY;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_MOD;
                end
            end
            S_ALLOC:
            begin
                // free stack read is in flight
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take = 1'b1;
                if (sts.empty)
                begin
                    cmd.link_self = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.steps_zero)
                begin
                    if (sts.is_insert)
                    begin
                        cmd.ins_link1 = 1'b1;
                        state_next    = S_INS_LINK;
                    end
                    else
                    begin
                        cmd.rem_commit = 1'b1;
                        state_next     = S_REM_DATA;
                    end
                end
            end
            S_INS_LINK:
            begin
                cmd.ins_link2 = 1'b1;
                state_next    = S_IDLE;
            end
            S_REM_DATA:
            begin
                cmd.rem_finish = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/clrr_dp.sv -----
// ----------------------------------------------------------------------------
// clrr_dp
// Datapath: node memories, free node stack, list pointers, bit-serial
// remainder unit, link walker and result register.
// ----------------------------------------------------------------------------
module clrr_dp #(
    parameter int POOL_DEPTH = clrr_pkg::POOL_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  clrr_pkg::req_t req,
    input  clrr_pkg::cmd_t cmd,
    output clrr_pkg::sts_t sts,
    output logic           done,
    output clrr_pkg::rsp_t rsp
);

    import clrr_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int DW = VAL_W + TAG_W;

    req_t               req_reg;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rec_reg, rec_next;
    logic [CW-1:0]      fresh_reg, fresh_next;
    logic [IW-1:0]      at_reg, at_next;
    logic [IW-1:0]      pre_reg, pre_next;
    logic [IW-1:0]      n_reg, n_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [POS_W-1:0]   dvd_reg, dvd_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    rsp_t               rsp_reg, rsp_next;
    logic               done_reg, done_next;

    logic [IW-1:0]      n_new;
    logic [CW:0]        trial;
    logic [CW-1:0]      rec_m1;
    logic [LEN_W+CW-1:0] len_ext;

    logic               link_we;
    logic [IW-1:0]      link_waddr, link_wdata, link_raddr, link_rdata;
    logic               stack_we;
    logic [IW-1:0]      stack_rdata;
    logic [DW-1:0]      data_rdata;

    clrr_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    clrr_ram #(.WIDTH(DW), .DEPTH(POOL_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (cmd.take),
        .waddr (n_new),
        .wdata ({req_reg.value, req_reg.tag}),
        .raddr (at_reg),
        .rdata (data_rdata)
    );

    // recycled nodes only; never-used nodes come from the fresh counter
    clrr_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (rec_reg[IW-1:0]),
        .wdata (at_reg),
        .raddr (rec_m1[IW-1:0]),
        .rdata (stack_rdata)
    );

    assign rec_m1   = rec_reg - CW'(1);
    assign n_new    = (rec_reg != '0) ? stack_rdata : fresh_reg[IW-1:0];
    assign stack_we = cmd.rem_commit;
    assign trial    = {rem_reg, dvd_reg[POS_W-1]};

    // while walking, the next address is the link just read
    assign link_raddr = cmd.walk ? link_rdata : at_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = n_reg;
        link_wdata = link_rdata;
        if (cmd.link_self)
        begin
            link_we    = 1'b1;
            link_waddr = n_new;
            link_wdata = n_new;
        end
        else if (cmd.ins_link1)
        begin
            link_we    = 1'b1;
            link_waddr = n_reg;
            link_wdata = link_rdata;
        end
        else if (cmd.ins_link2)
        begin
            link_we    = 1'b1;
            link_waddr = at_reg;
            link_wdata = n_reg;
        end
        else if (cmd.rem_commit)
        begin
            link_we    = 1'b1;
            link_waddr = pre_reg;
            link_wdata = link_rdata;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        rec_next   = rec_reg;
        fresh_next = fresh_reg;
        at_next    = at_reg;
        pre_next   = pre_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        bit_next   = bit_reg;

        if (cmd.setup)
        begin
            at_next  = head_reg;
            pre_next = tail_reg;
            rem_next = '0;
            bit_next = BIT_CNT_W'(POS_W);
            if (req_reg.operation == OP_INSERT)
            begin
                dvd_next = (req_reg.position > POS_W'(1)) ?
                           req_reg.position - POS_W'(1) : '0;
            end
            else
            begin
                dvd_next = req_reg.skip_count;
            end
        end

        if (cmd.take)
        begin
            n_next = n_new;
            if (rec_reg != '0)
            begin
                rec_next = rec_m1;
            end
            else
            begin
                fresh_next = fresh_reg + CW'(1);
            end
        end

        if (cmd.link_self)
        begin
            head_next  = n_new;
            tail_next  = n_new;
            count_next = count_reg + CW'(1);
        end

        // restoring remainder, one dividend bit per cycle
        if (cmd.mod_step)
        begin
            if (trial >= {1'b0, count_reg})
            begin
                rem_next = CW'(trial - {1'b0, count_reg});
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            bit_next = bit_reg - BIT_CNT_W'(1);
        end

        if (cmd.walk && (rem_reg != '0))
        begin
            pre_next = at_reg;
            at_next  = link_rdata;
            rem_next = rem_reg - CW'(1);
        end

        if (cmd.ins_link1 && (link_rdata == head_reg))
        begin
            tail_next = n_reg;
        end

        if (cmd.ins_link2)
        begin
            count_next = count_reg + CW'(1);
        end

        if (cmd.rem_commit)
        begin
            rec_next   = rec_reg + CW'(1);
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                head_next = link_rdata;
                tail_next = pre_reg;
            end
        end
    end

    assign len_ext = {{LEN_W{1'b0}}, count_next};

    always_comb
    begin
        done_next = cmd.fin_err | cmd.link_self | cmd.ins_link2 | cmd.rem_finish;
        rsp_next  = rsp_reg;
        if (done_next)
        begin
            rsp_next.removed_value = '0;
            rsp_next.removed_tag   = '0;
            rsp_next.status        = cmd.fin_err ? cmd.err_code : ST_OK;
            rsp_next.list_length   = len_ext[LEN_W-1:0];
            if (cmd.rem_finish)
            begin
                rsp_next.removed_value = data_rdata[DW-1:TAG_W];
                rsp_next.removed_tag   = data_rdata[TAG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            rec_reg   <= '0;
            fresh_reg <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            rec_reg   <= rec_next;
            fresh_reg <= fresh_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        at_reg  <= at_next;
        pre_reg <= pre_next;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        rsp_reg <= rsp_next;
    end

    assign sts.is_insert  = (req_reg.operation == OP_INSERT);
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(POOL_DEPTH));
    assign sts.mod_last   = (bit_reg == BIT_CNT_W'(1));
    assign sts.steps_zero = (rem_reg == '0);

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
